>>> rtl/core/indexed_bitmap_pixel_unpacker_unit_macros.svh
// Assertion helpers for the pixel unpacker. Empty in synthesis builds.
`ifndef INDEXED_BITMAP_PIXEL_UNPACKER_UNIT_MACROS_SVH
`define INDEXED_BITMAP_PIXEL_UNPACKER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// plain property, checked on every edge outside reset
`define IBPU_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication
`define IBPU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define IBPU_ASSERT(lbl, clk, rst_n, prop, msg)
`define IBPU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/ibpu_pkg.sv
package ibpu_pkg;

	localparam int unsigned PAL_ENTRIES = 256;
	localparam int unsigned PAL_AW = $clog2(PAL_ENTRIES);
	localparam int unsigned COLOR_W = 24;
	localparam int unsigned COORD_W = 12;
	localparam int unsigned UNIT_W = 16;
	localparam int unsigned CFG_DATA_W = 14;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEPTH_MODE   = 3'd0,
		REG_DRAW_FLAGS   = 3'd1,
		REG_X_ORIGIN     = 3'd2,
		REG_Y_ORIGIN     = 3'd3,
		REG_ROW_WIDTH    = 3'd4,
		REG_IMAGE_HEIGHT = 3'd5,
		REG_BYTES_LINE   = 3'd6,
		REG_FIRST_OFFSET = 3'd7
	} cfg_reg_t;

	localparam logic [2:0] DEPTH_1BPP  = 3'd0;
	localparam logic [2:0] DEPTH_2BPP  = 3'd1;
	localparam logic [2:0] DEPTH_4BPP  = 3'd2;
	localparam logic [2:0] DEPTH_8BPP  = 3'd3;
	localparam logic [2:0] DEPTH_16BPP = 3'd4;

	localparam int unsigned FLAG_TRANSP = 0;
	localparam int unsigned FLAG_PALETTE = 1;

	localparam logic CMD_PALETTE = 1'b0;
	localparam logic CMD_PIXELS = 1'b1;

endpackage

>>> rtl/core/indexed_bitmap_pixel_unpacker_unit.sv
// Indexed bitmap pixel unpacker.
// Input channel (in_valid/in_stall): cmd 0 writes palette_color into palette entry
// palette_index; cmd 1 delivers one source byte (or one 16-bit pixel at 16 bpp).
// Output channel (out_valid/out_stall): one pixel write per transfer, with
// last_of_item set on the final pixel that one input item produced.
// Configuration channel (cfg_valid/cfg_ready): cfg_ready is always high; any write
// restarts the image at column 0, row 0. Write only while the block is idle.
// The first pixel of an item passes through the unpack stage and the output stage
// register; pixels leave at one pixel per cycle unless the receiver stalls. A data
// item holds the unpack stage until it issues its last pixel (up to 8 at 1 bpp);
// palette writes pass through it without drawing, and items that draw nothing never
// enter it. The next item is taken in the cycle the current one issues its last pixel,
// so pixel output from consecutive data items runs without gaps.
// The palette is a 256 x 24 memory with a registered read port; it is not
// cleared by reset and an entry must be written before it is used.
// Reset clears all control state and loads the register defaults
// (8 bpp, width 1, height 1, one byte per line).
// When the receiver stalls, the output pixel holds, the unpack stage holds,
// and in_stall rises once the unpack stage has work it cannot pass on.
`include "indexed_bitmap_pixel_unpacker_unit_macros.svh"

module indexed_bitmap_pixel_unpacker_unit import ibpu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic [UNIT_W-1:0]     data_unit,
	input  logic [7:0]            palette_index,
	input  logic [COLOR_W-1:0]    palette_color,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COORD_W-1:0]    pixel_x,
	output logic [COORD_W-1:0]    pixel_y,
	output logic [COLOR_W-1:0]    pixel_color,
	output logic                  last_of_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	function automatic logic [UNIT_W-1:0] unit_index(input logic [UNIT_W-1:0] unit,
			input logic [2:0] mode, input logic [2:0] slot);
		logic [UNIT_W-1:0] idx;
		idx = '0;
		case (mode)
			DEPTH_1BPP: idx = UNIT_W'(unit[slot]);
			DEPTH_2BPP: idx = UNIT_W'((unit[7:0] >> {~slot[1:0], 1'b0}) & 8'h03);
			DEPTH_4BPP: idx = UNIT_W'((unit[7:0] >> {~slot[0], 2'b00}) & 8'h0F);
			DEPTH_8BPP: idx = UNIT_W'(unit[7:0]);
			default:    idx = unit;
		endcase
		return idx;
	endfunction

	// configuration registers
	logic [2:0]         depth_q;
	logic [1:0]         flags_q;
	logic [COORD_W-1:0] x_org_q;
	logic [COORD_W-1:0] y_org_q;
	logic [12:0]        width_q;
	logic [12:0]        height_q;
	logic [13:0]        bpl_q;
	logic [2:0]         offset_q;

	// image position
	logic [12:0] col_q;
	logic [12:0] row_q;
	logic [13:0] byte_q;

	// unpack stage
	logic               v_s1;
	logic               pal_s1;
	logic [7:0]         mask_s1;
	logic [UNIT_W-1:0]  unit_s1;
	logic [2:0]         mode_s1;
	logic               usepal_s1;
	logic [COORD_W-1:0] base_x_s1;
	logic [COORD_W-1:0] y_s1;
	logic [7:0]         pidx_s1;
	logic [COLOR_W-1:0] pcol_s1;

	// output stage
	logic               v_s2;
	logic [COORD_W-1:0] x_s2;
	logic [COORD_W-1:0] y_s2;
	logic [UNIT_W-1:0]  idx_s2;
	logic               usepal_s2;
	logic               pal_ok_s2;
	logic               last_s2;
	logic [COLOR_W-1:0] pal_rd_s2;

	logic [COLOR_W-1:0] palette_mem [PAL_ENTRIES];

	logic        cfg_wr;
	logic        in_acc;
	logic        pix_go;
	logic        load_s1;
	logic [3:0]  ppb;
	logic [2:0]  slot0;
	logic [3:0]  avail;
	logic [12:0] room;
	logic [3:0]  n_pix;
	logic [3:0]  slot_end;
	logic [14:0] total;
	logic        row_end;
	logic [7:0]  mask_new;

	logic              s2_free;
	logic              emit;
	logic              s1_done;
	logic [7:0]        sel_onehot;
	logic [7:0]        rest;
	logic [2:0]        sel;
	logic [UNIT_W-1:0] sel_idx;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign in_acc = in_valid && !in_stall;

	// position bookkeeping for an incoming data unit
	always_comb begin
		case (depth_q)
			DEPTH_1BPP: ppb = 4'd8;
			DEPTH_2BPP: ppb = 4'd4;
			DEPTH_4BPP: ppb = 4'd2;
			default:    ppb = 4'd1;
		endcase
		slot0 = '0;
		if (byte_q == '0 && depth_q < DEPTH_8BPP) begin
			slot0 = offset_q & 3'(ppb - 4'd1);
		end
		avail = ppb - {1'b0, slot0};
		room = (col_q < width_q) ? (width_q - col_q) : '0;
		n_pix = (room < {9'd0, avail}) ? room[3:0] : avail;
		slot_end = {1'b0, slot0} + n_pix;
		total = {1'b0, byte_q} + ((depth_q == DEPTH_16BPP) ? 15'd2 : 15'd1);
		row_end = total >= {1'b0, bpl_q};
		pix_go = in_acc && cmd == CMD_PIXELS && depth_q <= DEPTH_16BPP && row_q < height_q;
		for (int s = 0; s < 8; s++) begin
			mask_new[s] = (4'(s) >= {1'b0, slot0}) && (4'(s) < slot_end)
				&& !(flags_q[FLAG_TRANSP] && unit_index(data_unit, depth_q, 3'(s)) == '0);
		end
	end

	assign load_s1 = in_acc && (cmd == CMD_PALETTE || (pix_go && mask_new != '0));

	// pick the lowest pending slot
	always_comb begin
		sel_onehot = mask_s1 & (~mask_s1 + 8'd1);
		rest = mask_s1 & ~sel_onehot;
		sel = '0;
		for (int i = 7; i >= 0; i--) begin
			if (mask_s1[i]) begin
				sel = 3'(i);
			end
		end
		sel_idx = unit_index(unit_s1, mode_s1, sel);
	end

	assign s2_free = !v_s2 || !out_stall;
	assign emit = v_s1 && !pal_s1 && s2_free;
	assign s1_done = v_s1 && (pal_s1 || (s2_free && rest == '0));
	assign in_stall = v_s1 && !s1_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_8BPP;
			flags_q <= '0;
			x_org_q <= '0;
			y_org_q <= '0;
			width_q <= 13'd1;
			height_q <= 13'd1;
			bpl_q <= 14'd1;
			offset_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DEPTH_MODE:   depth_q <= cfg_data[2:0];
				REG_DRAW_FLAGS:   flags_q <= cfg_data[1:0];
				REG_X_ORIGIN:     x_org_q <= cfg_data[COORD_W-1:0];
				REG_Y_ORIGIN:     y_org_q <= cfg_data[COORD_W-1:0];
				REG_ROW_WIDTH:    width_q <= cfg_data[12:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[12:0];
				REG_BYTES_LINE:   bpl_q <= cfg_data[13:0];
				REG_FIRST_OFFSET: offset_q <= cfg_data[2:0];
				default:          depth_q <= depth_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			byte_q <= '0;
		end else if (cfg_wr) begin
			// restart the image
			col_q <= '0;
			row_q <= '0;
			byte_q <= '0;
		end else if (pix_go) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= row_q + 13'd1;
				byte_q <= '0;
			end else begin
				col_q <= col_q + 13'(n_pix);
				byte_q <= total[13:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			mask_s1 <= '0;
		end else if (load_s1) begin
			v_s1 <= 1'b1;
			mask_s1 <= (cmd == CMD_PALETTE) ? 8'h00 : mask_new;
		end else if (s1_done) begin
			v_s1 <= 1'b0;
			mask_s1 <= '0;
		end else if (emit) begin
			mask_s1 <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			pal_s1 <= (cmd == CMD_PALETTE);
			unit_s1 <= data_unit;
			mode_s1 <= depth_q;
			usepal_s1 <= flags_q[FLAG_PALETTE] && depth_q != DEPTH_16BPP;
			base_x_s1 <= x_org_q + col_q[COORD_W-1:0] - {{(COORD_W-3){1'b0}}, slot0};
			y_s1 <= y_org_q + row_q[COORD_W-1:0];
			pidx_s1 <= palette_index;
			pcol_s1 <= palette_color;
		end
	end

	// palette write happens in order, once earlier pixels have done their reads
	always_ff @(posedge clk) begin
		if (v_s1 && pal_s1 && ({1'b0, pidx_s1} < 9'(PAL_ENTRIES))) begin
			palette_mem[pidx_s1[PAL_AW-1:0]] <= pcol_s1;
		end
		if (emit) begin
			pal_rd_s2 <= palette_mem[sel_idx[PAL_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (emit) begin
			v_s2 <= 1'b1;
		end else if (!out_stall) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			x_s2 <= base_x_s1 + COORD_W'(sel);
			y_s2 <= y_s1;
			idx_s2 <= sel_idx;
			usepal_s2 <= usepal_s1;
			pal_ok_s2 <= {{(UNIT_W-PAL_AW){1'b0}}, 1'b0} == '0
				&& ({1'b0, sel_idx} < 17'(PAL_ENTRIES));
			last_s2 <= (rest == '0);
		end
	end

	assign out_valid = v_s2;
	assign pixel_x = x_s2;
	assign pixel_y = y_s2;
	assign last_of_item = last_s2;
	assign pixel_color = usepal_s2 ? (pal_ok_s2 ? pal_rd_s2 : '0) : COLOR_W'(idx_s2);

	`IBPU_ASSERT_IMPL(a_stall_needs_work, clk, arst_n, in_stall, v_s1, "stall while empty")
	`IBPU_ASSERT_IMPL(a_pixel_work_pending, clk, arst_n, v_s1 && !pal_s1, |mask_s1, "no pixels")
	`IBPU_ASSERT(a_row_in_bounds, clk, arst_n, row_q <= height_q, "row count past image height")
	`IBPU_ASSERT(a_byte_in_bounds, clk, arst_n, byte_q < bpl_q || byte_q == '0, "byte count high")

endmodule
